// ===== rtl/cartridge_irq_timer_multiplier_regs_unit_macros.svh =====
// Assertion macros used by the register unit's top-level RTL.
`ifndef CARTRIDGE_IRQ_TIMER_MULTIPLIER_REGS_UNIT_MACROS_SVH
`define CARTRIDGE_IRQ_TIMER_MULTIPLIER_REGS_UNIT_MACROS_SVH

// same-cycle implication, clocked on clock, off while reset is high
`define CITMR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("citmr assertion failed");

// next-cycle implication
`define CITMR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("citmr assertion failed");

`endif

// ===== rtl/citmr_pkg.sv =====
// Types and constants of the cartridge IRQ, timer and multiplier register unit.
package citmr_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   localparam logic [15:0] ADDR_LINE_CMP  = 16'h5203;
   localparam logic [15:0] ADDR_LINE_CTRL = 16'h5204;
   localparam logic [15:0] ADDR_MUL_A     = 16'h5205;
   localparam logic [15:0] ADDR_MUL_B     = 16'h5206;
   localparam logic [15:0] ADDR_TMR_LO    = 16'h5209;
   localparam logic [15:0] ADDR_TMR_HI    = 16'h520A;
   localparam logic [15:0] EXT_WIN_LO     = 16'h5C00;
   localparam logic [15:0] EXT_WIN_HI     = 16'h5FFF;

   localparam logic [7:0]  UNMAPPED_DATA  = 8'hFF;
   localparam logic [7:0]  LAST_LINE      = 8'd239;
   localparam logic [15:0] STEP_RESET     = 16'd114;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        vblank;
   } item_type;

   typedef struct packed {
      logic        we;
      logic        re;
      logic [15:0] address;
      logic [7:0]  wdata;
   } ram_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_hit;
      logic       sel_ram;
      logic [1:0] irq_pulses;
      logic       irq_level;
   } res_type;

endpackage

// ===== rtl/citmr_ifs.sv =====
// Valid/ready channel interfaces for request and response beats.
interface citmr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic        vblank;

   modport source (output valid, operation, address, write_data, vblank, input ready);
   modport sink (input valid, operation, address, write_data, vblank, output ready);
endinterface

interface citmr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       read_hit;
   logic [1:0] irq_pulses;
   logic       irq_level;

   modport source (output valid, read_data, read_hit, irq_pulses, irq_level, input ready);
   modport sink (input valid, read_data, read_hit, irq_pulses, irq_level, output ready);
endinterface

// ===== rtl/cartridge_irq_timer_multiplier_regs_unit.sv =====
// Top level: request decode, extended RAM and two-stage response pipeline.
//
//  port group  dir  beat contents
//  req_chan    in   operation, address, write_data, vblank
//  rsp_chan    out  read_data, read_hit, irq_pulses, irq_level
//  csr_*       in   timer_step write (csr_we, csr_wdata)
//
// One beat per cycle unless rsp_chan stalls or the RAM clears; a response passes
// the middle stage, then the response register. Register and RAM updates happen
// at acceptance; RAM read data lands in the middle stage, the response register
// holds it, so one more beat is taken while a response waits. After reset all
// EXT_RAM_DEPTH words (1024 default) are zeroed; requests wait, csr writes don't.

`include "cartridge_irq_timer_multiplier_regs_unit_macros.svh"

module cartridge_irq_timer_multiplier_regs_unit
   import citmr_pkg::*;
#(
   parameter int EXT_RAM_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   citmr_req_if.sink   req_chan,
   citmr_rsp_if.source rsp_chan,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   item_type    item;
   ram_req_type ram_req;
   res_type     res;
   logic        accept;
   logic        clr_busy;
   logic [7:0]  ram_q;

   logic        a_vld_ff, a_vld_in;
   res_type     a_res_ff;
   logic        a_move;
   logic        rsp_vld_ff, rsp_vld_in;
   logic [7:0]  rsp_data_ff;
   logic        rsp_hit_ff;
   logic [1:0]  rsp_pulses_ff;
   logic        rsp_level_ff;

   assign item.operation  = req_chan.operation;
   assign item.address    = req_chan.address;
   assign item.write_data = req_chan.write_data;
   assign item.vblank     = req_chan.vblank;

   assign a_move         = a_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !clr_busy && (!a_vld_ff || a_move);
   assign accept         = req_chan.valid && req_chan.ready;

   citmr_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .ram_req   (ram_req),
      .res       (res)
   );

   citmr_ram #(
      .DEPTH (EXT_RAM_DEPTH)
   ) u_ram (
      .clock    (clock),
      .reset    (reset),
      .req      (ram_req),
      .rd_data  (ram_q),
      .clr_busy (clr_busy)
   );

   always_comb begin
      a_vld_in = a_vld_ff;
      if (accept) begin
         a_vld_in = 1'b1;
      end else if (a_move) begin
         a_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (a_move) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         a_vld_ff   <= a_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_res_ff <= res;
      end
      if (a_move) begin
         rsp_data_ff   <= a_res_ff.sel_ram ? ram_q : a_res_ff.read_data;
         rsp_hit_ff    <= a_res_ff.read_hit;
         rsp_pulses_ff <= a_res_ff.irq_pulses;
         rsp_level_ff  <= a_res_ff.irq_level;
      end
   end

   assign rsp_chan.valid      = rsp_vld_ff;
   assign rsp_chan.read_data  = rsp_data_ff;
   assign rsp_chan.read_hit   = rsp_hit_ff;
   assign rsp_chan.irq_pulses = rsp_pulses_ff;
   assign rsp_chan.irq_level  = rsp_level_ff;

   `CITMR_ASSERT_NOW(a_no_req_in_clear, clr_busy, !req_chan.ready)
   `CITMR_ASSERT_NEXT(a_mid_holds, a_vld_ff && !a_move, a_vld_ff)
   `CITMR_ASSERT_NOW(a_ram_sel_hits, a_vld_ff && a_res_ff.sel_ram, a_res_ff.read_hit)
   `CITMR_ASSERT_NOW(a_pulses_range, rsp_vld_ff, rsp_pulses_ff != 2'd3)

endmodule

// ===== rtl/citmr_ram.sv =====
// Extended RAM: single-port synchronous memory with a zeroing sweep after reset.
module citmr_ram
   import citmr_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  ram_req_type req,
   output logic [7:0]  rd_data,
   output logic        clr_busy
);

   localparam int Aw = $clog2(DEPTH);

   logic [7:0]    mem [DEPTH];
   logic [Aw-1:0] clr_addr_ff, clr_addr_in;
   logic          clr_busy_ff, clr_busy_in;
   logic [Aw-1:0] acc_addr;
   logic [7:0]    rd_data_ff;

   assign acc_addr = req.address[Aw-1:0];
   assign clr_busy = clr_busy_ff;
   assign rd_data  = rd_data_ff;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == Aw'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= 8'h00;
      end else if (req.we) begin
         mem[acc_addr] <= req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req.re) begin
         rd_data_ff <= mem[acc_addr];
      end
   end

endmodule

// ===== rtl/citmr_regs.sv =====
// Register file: decode, scanline IRQ, multiplier and countdown timer state.
module citmr_regs
   import citmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  item_type    item,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output ram_req_type ram_req,
   output res_type     res
);

   typedef struct packed {
      logic [7:0]  line_compare;
      logic        line_irq_enable;
      logic        line_irq_pending;
      logic        line_irq_held;
      logic        inside_frame;
      logic        was_vblank;
      logic [7:0]  line_number;
      logic [7:0]  factor_a;
      logic [7:0]  factor_b;
      logic [15:0] countdown;
      logic        countdown_running;
      logic        countdown_flag;
      logic        countdown_held;
   } state_type;

   localparam state_type StReset = '{
      line_compare: 8'd0, line_irq_enable: 1'b0, line_irq_pending: 1'b0,
      line_irq_held: 1'b0, inside_frame: 1'b0, was_vblank: 1'b1,
      line_number: 8'd0, factor_a: 8'd0, factor_b: 8'd0, countdown: 16'd0,
      countdown_running: 1'b0, countdown_flag: 1'b0, countdown_held: 1'b0
   };

   state_type   st_ff, st_in;
   logic [15:0] timer_step_ff, timer_step_in;
   logic [15:0] prod;
   logic [1:0]  edges;
   logic        ext_hit;

   assign ext_hit = (item.address >= EXT_WIN_LO) && (item.address <= EXT_WIN_HI);
   assign prod    = 16'(st_ff.factor_a) * 16'(st_ff.factor_b);
   assign timer_step_in = csr_we ? csr_wdata : timer_step_ff;

   always_comb begin
      st_in           = st_ff;
      edges           = 2'd0;
      res             = '0;
      ram_req.we      = 1'b0;
      ram_req.re      = 1'b0;
      ram_req.address = item.address;
      ram_req.wdata   = item.write_data;
      if (accept) begin
         case (item.operation)
            OP_WRITE: begin
               if (ext_hit) begin
                  ram_req.we = 1'b1;
               end else begin
                  case (item.address)
                     ADDR_LINE_CMP: st_in.line_compare = item.write_data;
                     ADDR_LINE_CTRL: begin
                        st_in.line_irq_enable = item.write_data[7];
                        if (!item.write_data[7]) begin
                           st_in.line_irq_pending = 1'b0;
                           st_in.line_irq_held    = 1'b0;
                        end
                     end
                     ADDR_MUL_A: st_in.factor_a = item.write_data;
                     ADDR_MUL_B: st_in.factor_b = item.write_data;
                     ADDR_TMR_LO: begin
                        st_in.countdown         = {st_ff.countdown[15:8], item.write_data};
                        st_in.countdown_running = 1'b1;
                     end
                     ADDR_TMR_HI: st_in.countdown = {item.write_data, st_ff.countdown[7:0]};
                     default: ;
                  endcase
               end
            end
            OP_READ: begin
               res.read_hit = 1'b1;
               if (ext_hit) begin
                  ram_req.re  = 1'b1;
                  res.sel_ram = 1'b1;
               end else begin
                  case (item.address)
                     ADDR_LINE_CTRL: begin
                        res.read_data = {st_ff.inside_frame, st_ff.line_irq_pending, 6'd0};
                        st_in.line_irq_pending = 1'b0;
                        st_in.line_irq_held    = 1'b0;
                     end
                     ADDR_MUL_A: res.read_data = prod[7:0];
                     ADDR_MUL_B: res.read_data = prod[15:8];
                     ADDR_TMR_LO: begin
                        res.read_data        = {st_ff.countdown_flag, 7'd0};
                        st_in.countdown_flag = 1'b0;
                        st_in.countdown_held = 1'b0;
                     end
                     default: begin
                        res.read_data = UNMAPPED_DATA;
                        res.read_hit  = 1'b0;
                     end
                  endcase
               end
            end
            OP_TICK: begin
               if (item.vblank) begin
                  st_in.inside_frame     = 1'b0;
                  st_in.was_vblank       = 1'b1;
                  st_in.line_irq_held    = 1'b0;
                  st_in.line_irq_pending = 1'b0;
                  st_in.countdown_held   = 1'b0;
               end else begin
                  st_in.inside_frame = 1'b1;
                  if (st_ff.was_vblank) begin
                     st_in.was_vblank  = 1'b0;
                     st_in.line_number = 8'd0;
                  end else if (st_ff.line_number < LAST_LINE) begin
                     st_in.line_number = st_ff.line_number + 8'd1;
                  end
               end
               if (st_in.line_irq_enable && st_in.inside_frame &&
                   (st_in.line_number == st_in.line_compare)) begin
                  st_in.line_irq_pending = 1'b1;
                  if (!st_in.line_irq_held) begin
                     st_in.line_irq_held = 1'b1;
                     edges = edges + 2'd1;
                  end
               end
               if (st_ff.countdown_running && (st_ff.countdown != 16'd0)) begin
                  if (st_ff.countdown > timer_step_ff) begin
                     st_in.countdown = st_ff.countdown - timer_step_ff;
                  end else begin
                     st_in.countdown      = 16'd0;
                     st_in.countdown_flag = 1'b1;
                     if (!st_in.countdown_held) begin
                        st_in.countdown_held = 1'b1;
                        edges = edges + 2'd1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      res.irq_pulses = edges;
      res.irq_level  = st_in.line_irq_held | st_in.countdown_held;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= StReset;
         timer_step_ff <= STEP_RESET;
      end else begin
         st_ff         <= st_in;
         timer_step_ff <= timer_step_in;
      end
   end

endmodule
